>>> design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the modular multiply-add stream unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    // field widths
    localparam int MOD_W   = 61;
    localparam int OP_W    = 63;
    localparam int RES_W   = 61;
    localparam int MU_W    = 64;
    localparam int SHIFT_W = 6;
    localparam int WIDTH_W = 6;
    localparam int EXP_W   = 7;

    // barrett exponent offset: mu = floor(2^(n + MU_EXP_OFS) / q)
    localparam logic [EXP_W-1:0] MU_EXP_OFS = 7'd62;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam logic [1:0] REG_MODULUS    = 2'd0;
    localparam logic [1:0] REG_MULTIPLIER = 2'd1;
    localparam logic [1:0] REG_RANGE_CODE = 2'd2;
    localparam logic [1:0] REG_ADD_ENABLE = 2'd3;

    // reset values (mu and width match a modulus of two)
    localparam logic [MOD_W-1:0]   MODULUS_RST = 61'd2;
    localparam logic [MU_W-1:0]    MU_RST      = 64'h8000_0000_0000_0000;
    localparam logic [WIDTH_W-1:0] WIDTH_RST   = 6'd2;

    // configuration and the constants derived from it, consumed by the datapath
    typedef struct packed {
        logic [MOD_W-1:0]   modulus;
        logic [OP_W-1:0]    mult_red;
        logic [MU_W-1:0]    mu;
        logic [SHIFT_W-1:0] shift;
        logic [1:0]         range_code;
        logic               add_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIDTH,
        ST_DIVIDE,
        ST_REDUCE_HI,
        ST_REDUCE_LO
    } setup_state_t;

endpackage

`default_nettype wire

>>> design/mma_if.sv
// ----------------------------------------------------------------------------
// mma_in_if / mma_out_if
// Valid-ready channels carrying operand items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_in_if;
    logic                     valid;
    logic                     ready;
    logic [mma_pkg::OP_W-1:0] operand;
    logic [mma_pkg::OP_W-1:0] addend;
    logic                     last_in;

    modport source (output valid, output operand, output addend, output last_in,
                    input ready);
    modport sink   (input valid, input operand, input addend, input last_in,
                    output ready);
endinterface

interface mma_out_if;
    logic                      valid;
    logic                      ready;
    logic [mma_pkg::RES_W-1:0] result;
    logic                      last_out;

    modport source (output valid, output result, output last_out, input ready);
    modport sink   (input valid, input result, input last_out, output ready);
endinterface

`default_nettype wire

>>> design/mma_setup.sv
// ----------------------------------------------------------------------------
// mma_setup
// Derives the Barrett constant mu, the product shift and the reduced
// multiplier after a write to modulus, multiplier or range code.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_setup (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mma_pkg::MOD_W-1:0]     modulus,
    input  wire logic [mma_pkg::OP_W-1:0]      multiplier,
    input  wire logic [1:0]                    range_code,
    output logic      [mma_pkg::MU_W-1:0]      mu,
    output logic      [mma_pkg::SHIFT_W-1:0]   shift,
    output logic      [mma_pkg::OP_W-1:0]      mult_red,
    output logic                               busy
);

    mma_pkg::setup_state_t state_reg, state_next;

    logic [mma_pkg::MOD_W-1:0]   scan_reg;
    logic [mma_pkg::WIDTH_W-1:0] width_reg;
    logic [mma_pkg::EXP_W-1:0]   exp_reg;
    logic [mma_pkg::EXP_W-1:0]   cnt_reg;
    logic [mma_pkg::MOD_W:0]     rem_reg;
    logic [mma_pkg::MU_W-1:0]    quo_reg;
    logic [mma_pkg::OP_W-1:0]    mult_reg;

    logic [mma_pkg::MOD_W:0]     rem_shift;
    logic                        rem_ge;
    logic [mma_pkg::MOD_W:0]     twice_q;

    // one restoring division step per cycle
    assign rem_shift = {rem_reg[mma_pkg::MOD_W-1:0], cnt_reg == exp_reg};
    assign rem_ge    = rem_shift >= {1'b0, modulus};
    assign twice_q   = {modulus, 1'b0};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        priority if (start)
        begin
            state_next = mma_pkg::ST_WIDTH;
        end
        else
        begin
            unique case (state_reg)
                mma_pkg::ST_IDLE:
                begin
                    busy = 1'b0;
                end
                mma_pkg::ST_WIDTH:
                begin
                    if (scan_reg == '0)
                    begin
                        state_next = mma_pkg::ST_DIVIDE;
                    end
                end
                mma_pkg::ST_DIVIDE:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = mma_pkg::ST_REDUCE_HI;
                    end
                end
                mma_pkg::ST_REDUCE_HI:
                begin
                    state_next = mma_pkg::ST_REDUCE_LO;
                end
                mma_pkg::ST_REDUCE_LO:
                begin
                    state_next = mma_pkg::ST_IDLE;
                end
                default:
                begin
                    state_next = mma_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            width_reg <= mma_pkg::WIDTH_RST;
            exp_reg   <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= mma_pkg::MU_RST;
            mult_reg  <= '0;
        end
        else if (start)
        begin
            scan_reg  <= modulus;
            width_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                mma_pkg::ST_WIDTH:
                begin
                    // count significant bits of the modulus
                    if (scan_reg != '0)
                    begin
                        scan_reg  <= scan_reg >> 1;
                        width_reg <= width_reg + 1'b1;
                    end
                    else
                    begin
                        exp_reg <= mma_pkg::EXP_W'(width_reg) + mma_pkg::MU_EXP_OFS;
                        cnt_reg <= mma_pkg::EXP_W'(width_reg) + mma_pkg::MU_EXP_OFS;
                        rem_reg <= '0;
                        quo_reg <= '0;
                    end
                end
                mma_pkg::ST_DIVIDE:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (rem_ge)
                    begin
                        rem_reg <= rem_shift - {1'b0, modulus};
                        quo_reg <= {quo_reg[mma_pkg::MU_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[mma_pkg::MU_W-2:0], 1'b0};
                    end
                end
                mma_pkg::ST_REDUCE_HI:
                begin
                    if (range_code[1] && multiplier >= {1'b0, twice_q})
                    begin
                        mult_reg <= multiplier - {1'b0, twice_q};
                    end
                    else
                    begin
                        mult_reg <= multiplier;
                    end
                end
                mma_pkg::ST_REDUCE_LO:
                begin
                    if (range_code != 2'd0 && mult_reg >= {2'b0, modulus})
                    begin
                        mult_reg <= mult_reg - {2'b0, modulus};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign mu       = quo_reg;
    assign shift    = width_reg - mma_pkg::WIDTH_W'(2);
    assign mult_red = mult_reg;

endmodule

`default_nettype wire

>>> design/mma_pipe.sv
// ----------------------------------------------------------------------------
// mma_pipe
// Thirteen-stage Barrett multiply-add datapath with per-stage valid bits
// and a ready chain, so bubbles close up under output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          hold,
    input  wire mma_pkg::cfg_t cfg,
    mma_in_if.sink             in_ch,
    mma_out_if.source          out_ch
);

    localparam int NSTG = 13;

    logic [NSTG:1] valid_reg;
    logic [NSTG:1] valid_next;
    logic [NSTG:1] en;
    logic [NSTG:1] last_reg;
    logic          take;

    logic [mma_pkg::MOD_W:0] twice_q;
    logic [mma_pkg::MOD_W-1:0] q;

    // payload registers
    logic [mma_pkg::OP_W-1:0] op1_reg;
    logic [mma_pkg::OP_W-1:0] x2_reg;
    logic [mma_pkg::OP_W-1:0] ad_reg [1:11];
    logic [63:0]              pll_reg;
    logic [62:0]              plh_reg;
    logic [62:0]              phl_reg;
    logic [61:0]              phh_reg;
    logic [125:0]             prod_reg;
    logic [63:0]              c1_reg;
    logic [63:0]              pl_reg [5:8];
    logic [63:0]              mll_reg;
    logic [63:0]              mlh_reg;
    logic [63:0]              mhl_reg;
    logic [63:0]              mhh_reg;
    logic [63:0]              ch_reg;
    logic [63:0]              qll_reg;
    logic [31:0]              qc1_reg;
    logic [31:0]              qc2_reg;
    logic [63:0]              z9_reg;
    logic [63:0]              z10_reg;
    logic [63:0]              z11_reg;
    logic [63:0]              z12_reg;
    logic [mma_pkg::RES_W-1:0] res_reg;

    logic [127:0] mu_sum;
    logic [63:0]  chq;
    logic [63:0]  z_fin;

    assign q       = cfg.modulus;
    assign twice_q = {q, 1'b0};

    // ready chain from the output back to the input
    always_comb
    begin
        en[NSTG] = !valid_reg[NSTG] || out_ch.ready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ch.ready = en[1] && !hold;
    assign take        = in_ch.valid && in_ch.ready;
    assign valid_next  = {valid_reg[NSTG-1:1], take};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NSTG; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // last flag travels with the item
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            last_reg[1] <= in_ch.last_in;
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (en[k])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    // addend carried to the add stage
    always_ff @(posedge clk)
    begin
        for (int k = 3; k <= 11; k++)
        begin
            if (en[k])
            begin
                ad_reg[k] <= ad_reg[k-1];
            end
        end
    end

    // stage 1: subtract 2q from operand and addend when range code bit 1 is set and they reach 2q
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            if (cfg.range_code[1] && in_ch.operand >= {1'b0, twice_q})
            begin
                op1_reg <= in_ch.operand - {1'b0, twice_q};
            end
            else
            begin
                op1_reg <= in_ch.operand;
            end
            if (cfg.range_code[1] && in_ch.addend >= {1'b0, twice_q})
            begin
                ad_reg[1] <= in_ch.addend - {1'b0, twice_q};
            end
            else
            begin
                ad_reg[1] <= in_ch.addend;
            end
        end
    end

    // stage 2: subtract q when the range code is nonzero and the value reaches q
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            if (cfg.range_code != 2'd0 && op1_reg >= {2'b0, q})
            begin
                x2_reg <= op1_reg - {2'b0, q};
            end
            else
            begin
                x2_reg <= op1_reg;
            end
            if (cfg.range_code != 2'd0 && ad_reg[1] >= {2'b0, q})
            begin
                ad_reg[2] <= ad_reg[1] - {2'b0, q};
            end
            else
            begin
                ad_reg[2] <= ad_reg[1];
            end
        end
    end

    // stage 3: partial products of x * y
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pll_reg <= 64'(x2_reg[31:0]) * 64'(cfg.mult_red[31:0]);
            plh_reg <= 63'(x2_reg[31:0]) * 63'(cfg.mult_red[62:32]);
            phl_reg <= 63'(x2_reg[62:32]) * 63'(cfg.mult_red[31:0]);
            phh_reg <= 62'(x2_reg[62:32]) * 62'(cfg.mult_red[62:32]);
        end
    end

    // stage 4: full product
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            prod_reg <= 126'(pll_reg) + (126'(plh_reg) << 32) + (126'(phl_reg) << 32)
                        + (126'(phh_reg) << 64);
        end
    end

    // stage 5: product shifted right by n-2
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            c1_reg    <= 64'(prod_reg >> cfg.shift);
            pl_reg[5] <= prod_reg[63:0];
        end
    end

    // stage 6: partial products of c1 * mu
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            mll_reg   <= 64'(c1_reg[31:0]) * 64'(cfg.mu[31:0]);
            mlh_reg   <= 64'(c1_reg[31:0]) * 64'(cfg.mu[63:32]);
            mhl_reg   <= 64'(c1_reg[63:32]) * 64'(cfg.mu[31:0]);
            mhh_reg   <= 64'(c1_reg[63:32]) * 64'(cfg.mu[63:32]);
            pl_reg[6] <= pl_reg[5];
        end
    end

    // stage 7: quotient estimate, high half of c1 * mu
    assign mu_sum = 128'(mll_reg) + (128'(mlh_reg) << 32) + (128'(mhl_reg) << 32)
                    + (128'(mhh_reg) << 64);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            ch_reg    <= mu_sum[127:64];
            pl_reg[7] <= pl_reg[6];
        end
    end

    // stage 8: partial products of the low half of estimate * q
    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            qll_reg   <= 64'(ch_reg[31:0]) * 64'(q[31:0]);
            qc1_reg   <= 32'(64'(ch_reg[31:0]) * 64'(q[60:32]));
            qc2_reg   <= 32'(64'(ch_reg[63:32]) * 64'(q[31:0]));
            pl_reg[8] <= pl_reg[7];
        end
    end

    // stage 9: remainder candidate
    assign chq = qll_reg + {32'(qc1_reg + qc2_reg), 32'h0};

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            z9_reg <= pl_reg[8] - chq;
        end
    end

    // stage 10: correct by 2q
    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            if (z9_reg >= 64'(twice_q))
            begin
                z10_reg <= z9_reg - 64'(twice_q);
            end
            else
            begin
                z10_reg <= z9_reg;
            end
        end
    end

    // stage 11: correct by q
    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            if (z10_reg >= 64'(q))
            begin
                z11_reg <= z10_reg - 64'(q);
            end
            else
            begin
                z11_reg <= z10_reg;
            end
        end
    end

    // stage 12: optional addend
    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            if (cfg.add_enable)
            begin
                z12_reg <= z11_reg + 64'(ad_reg[11]);
            end
            else
            begin
                z12_reg <= z11_reg;
            end
        end
    end

    // stage 13: final correction into the output register, zero for a modulus below two
    assign z_fin = (cfg.add_enable && z12_reg >= 64'(q)) ? z12_reg - 64'(q) : z12_reg;

    always_ff @(posedge clk)
    begin
        if (en[13])
        begin
            if (q[mma_pkg::MOD_W-1:1] == '0)
            begin
                res_reg <= '0;
            end
            else
            begin
                res_reg <= z_fin[mma_pkg::RES_W-1:0];
            end
        end
    end

    assign out_ch.valid    = valid_reg[NSTG];
    assign out_ch.result   = res_reg;
    assign out_ch.last_out = last_reg[NSTG];

endmodule

`default_nettype wire

>>> design/modular_multiply_add_stream_unit.sv
// ----------------------------------------------------------------------------
// modular_multiply_add_stream_unit
// Streaming (operand * multiplier + addend) mod q with Barrett reduction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  in_ch     sink       valid / ready    operand, addend, last_in
//  out_ch    source     valid / ready    result, last_out
//  apb       slave      psel / penable   modulus, multiplier, range code,
//                                        add enable (8-byte spaced)
//
//  one item per cycle through the datapath pipeline unless a stall backs
//  up to the input or a setup runs; a stalled output holds its item and
//  bubbles upstream are squeezed out; a write to modulus, multiplier or
//  range code starts the mu setup in the following cycle: width scan, n+63
//  division steps, high/low multiplier reduction, in_ch.ready low meanwhile
//  reset loads the constants of a modulus of two, no setup needed
// ----------------------------------------------------------------------------
`default_nettype none

module modular_multiply_add_stream_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    mma_in_if.sink                                  in_ch,
    mma_out_if.source                               out_ch,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mma_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [mma_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [mma_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    logic [mma_pkg::MOD_W-1:0] modulus_reg;
    logic [mma_pkg::OP_W-1:0]  multiplier_reg;
    logic [1:0]                range_code_reg;
    logic                      add_enable_reg;

    logic                      wr;
    logic [1:0]                reg_idx;
    logic                      setup_start;
    logic                      setup_start_reg;
    logic                      setup_busy;
    mma_pkg::cfg_t             cfg;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= mma_pkg::MODULUS_RST;
            multiplier_reg <= '0;
            range_code_reg <= '0;
            add_enable_reg <= 1'b0;
        end
        else if (wr)
        begin
            unique case (reg_idx)
                mma_pkg::REG_MODULUS:    modulus_reg    <= pwdata[mma_pkg::MOD_W-1:0];
                mma_pkg::REG_MULTIPLIER: multiplier_reg <= pwdata[mma_pkg::OP_W-1:0];
                mma_pkg::REG_RANGE_CODE: range_code_reg <= pwdata[1:0];
                mma_pkg::REG_ADD_ENABLE: add_enable_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            mma_pkg::REG_MODULUS:    prdata = mma_pkg::APB_DATA_W'(modulus_reg);
            mma_pkg::REG_MULTIPLIER: prdata = mma_pkg::APB_DATA_W'(multiplier_reg);
            mma_pkg::REG_RANGE_CODE: prdata = mma_pkg::APB_DATA_W'(range_code_reg);
            mma_pkg::REG_ADD_ENABLE: prdata = mma_pkg::APB_DATA_W'(add_enable_reg);
            default:                 prdata = '0;
        endcase
    end

    // recompute derived constants when the modulus side changes
    assign setup_start = wr && reg_idx != mma_pkg::REG_ADD_ENABLE;

    // start is registered so the setup sees the written register value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_start_reg <= 1'b0;
        end
        else
        begin
            setup_start_reg <= setup_start;
        end
    end

    mma_setup u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (setup_start_reg),
        .modulus    (modulus_reg),
        .multiplier (multiplier_reg),
        .range_code (range_code_reg),
        .mu         (cfg.mu),
        .shift      (cfg.shift),
        .mult_red   (cfg.mult_red),
        .busy       (setup_busy)
    );

    assign cfg.modulus    = modulus_reg;
    assign cfg.range_code = range_code_reg;
    assign cfg.add_enable = add_enable_reg;

    mma_pipe u_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .hold   (setup_busy),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
